FILE: sv/far_pkg.sv
// Shared types for the fraction add-and-reduce block.
package far_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_GCD1 = 12'b0000_0000_0010,
    ST_DIVA = 12'b0000_0000_0100,
    ST_DIVB = 12'b0000_0000_1000,
    ST_MUL1 = 12'b0000_0001_0000,
    ST_MUL2 = 12'b0000_0010_0000,
    ST_MUL3 = 12'b0000_0100_0000,
    ST_CHK  = 12'b0000_1000_0000,
    ST_GCD2 = 12'b0001_0000_0000,
    ST_DIVN = 12'b0010_0000_0000,
    ST_DIVD = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } far_state_e;

  // Control shared by every cell of the divider row.
  typedef struct packed {
    logic clear;
    logic step;
  } far_cell_ctrl_t;

endpackage

FILE: sv/fraction_add_reduce_core.sv
// Top level: adds two fractions and returns the sum in lowest terms.
//
// Usage: one input transfer on the s_axis group carries both fractions, each a
// signed numerator and a positive denominator (a zero denominator counts as one).
// One output transfer on the m_axis group carries the reduced sum; its
// denominator is always positive and a zero sum is returned as 0/1.
// Items are worked one at a time. The sequencer runs a binary gcd of the
// denominators, two divisions by that gcd, three multiplies, a gcd of the sum
// magnitude with the common denominator and two final divisions. Each division
// yields one quotient bit per cycle in the row of remainder cells; each gcd
// makes shift or subtract steps, at most about twice the combined width of its
// operands. A zero sum skips the second gcd and the last two divisions. The
// next input transfer can be taken in the cycle after the result is loaded.
// The result waits in an output register, so the next item is taken while the
// receiver stalls; only a second finished result waits for that register.
// Reset clears the sequencer and the output valid flag; no state spans items.
module fraction_add_reduce_core
  import far_pkg::*;
#(
  parameter int DATA_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // first_numerator, first_denominator, second_numerator, second_denominator
  input  logic [((4*DATA_BITS-2+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // sum_numerator, sum_denominator
  output logic [((((3*DATA_BITS > 64) ? 64 : 3*DATA_BITS) + 2*DATA_BITS-2 + 7)/8)*8-1:0]
               m_axis_tdata_o,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i
);

  localparam int D       = DATA_BITS;
  localparam int DW      = D - 1;
  localparam int W       = 2 * D;
  localparam int DEN_W   = 2 * D - 2;
  localparam int NUM_W   = (3 * D > 64) ? 64 : 3 * D;
  localparam int OUT_RAW = NUM_W + DEN_W;

  far_state_e state_q, state_d;

  logic signed [D-1:0] n1_q, n2_q;
  logic [DW-1:0]       d1_q, d2_q, a_q, b_q;
  logic [W-1:0]        g_q, mag_q;
  logic [DEN_W-1:0]    lcm_q, rden_q;
  logic signed [W-1:0] p_q, sum_q, rnum_q;
  logic                neg_q;

  logic [NUM_W-1:0]    onum_q;
  logic [DEN_W-1:0]    oden_q;
  logic                ovalid_q;

  logic                in_acc;
  logic [DW-1:0]       in_d1, in_d2;
  logic signed [D-1:0] mul_a, mul_b;
  logic signed [W-1:0] prod;
  logic [W-1:0]        mag;

  logic                gcd_start, gcd_done;
  logic [W-1:0]        gcd_x, gcd_y, gcd_g;
  logic                div_start, div_done;
  logic [W-1:0]        div_n, div_d, div_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_d1 = (s_axis_tdata_i[2*D-2:D] == '0) ? DW'(1) : s_axis_tdata_i[2*D-2:D];
  assign in_d2 = (s_axis_tdata_i[4*D-3:3*D-1] == '0) ? DW'(1)
                                                     : s_axis_tdata_i[4*D-3:3*D-1];

  // Magnitude of the sum; it always fits below the top bit.
  assign mag = sum_q[W-1] ? W'(-sum_q) : W'(sum_q);

  // Shared multiplier operands.
  always_comb begin
    mul_a = {1'b0, a_q};
    mul_b = {1'b0, d2_q};
    case (state_q)
      ST_MUL2: begin
        mul_a = n1_q;
        mul_b = {1'b0, b_q};
      end
      ST_MUL3: begin
        mul_a = n2_q;
        mul_b = {1'b0, a_q};
      end
      default: begin
        mul_a = {1'b0, a_q};
        mul_b = {1'b0, d2_q};
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Starts and operands of the shared gcd and divider units.
  assign gcd_start = in_acc || (state_q == ST_CHK && sum_q != '0);
  assign gcd_x     = (state_q == ST_CHK) ? mag : W'(in_d1);
  assign gcd_y     = (state_q == ST_CHK) ? W'(lcm_q) : W'(in_d2);

  assign div_start = (gcd_done && (state_q == ST_GCD1 || state_q == ST_GCD2)) ||
                     (div_done && (state_q == ST_DIVA || state_q == ST_DIVN));

  always_comb begin
    div_n = W'(d1_q);
    div_d = gcd_g;
    case (state_q)
      ST_GCD1: begin
        div_n = W'(d1_q);
        div_d = gcd_g;
      end
      ST_DIVA: begin
        div_n = W'(d2_q);
        div_d = g_q;
      end
      ST_GCD2: begin
        div_n = mag_q;
        div_d = gcd_g;
      end
      ST_DIVN: begin
        div_n = W'(lcm_q);
        div_d = g_q;
      end
      default: begin
        div_n = W'(d1_q);
        div_d = gcd_g;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_GCD1;
      ST_GCD1: if (gcd_done) state_d = ST_DIVA;
      ST_DIVA: if (div_done) state_d = ST_DIVB;
      ST_DIVB: if (div_done) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_CHK;
      ST_CHK:  state_d = (sum_q == '0) ? ST_DONE : ST_GCD2;
      ST_GCD2: if (gcd_done) state_d = ST_DIVN;
      ST_DIVN: if (div_done) state_d = ST_DIVD;
      ST_DIVD: if (div_done) state_d = ST_DONE;
      ST_DONE: if (!ovalid_q || m_axis_tready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && (!ovalid_q || m_axis_tready_i)) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      n1_q <= s_axis_tdata_i[D-1:0];
      d1_q <= in_d1;
      n2_q <= s_axis_tdata_i[3*D-2:2*D-1];
      d2_q <= in_d2;
    end
    if (gcd_done) begin
      g_q <= gcd_g;
    end
    case (state_q)
      ST_DIVA: if (div_done) a_q <= div_q[DW-1:0];
      ST_DIVB: if (div_done) b_q <= div_q[DW-1:0];
      ST_MUL1: lcm_q <= prod[DEN_W-1:0];
      ST_MUL2: p_q <= prod;
      ST_MUL3: sum_q <= p_q + prod;
      ST_CHK: begin
        mag_q <= mag;
        neg_q <= sum_q[W-1];
        if (sum_q == '0) begin
          rnum_q <= '0;
          rden_q <= DEN_W'(1);
        end
      end
      ST_DIVN: if (div_done) rnum_q <= neg_q ? -$signed(div_q) : $signed(div_q);
      ST_DIVD: if (div_done) rden_q <= div_q[DEN_W-1:0];
      default: begin
      end
    endcase
    if (state_q == ST_DONE && (!ovalid_q || m_axis_tready_i)) begin
      onum_q <= {{(NUM_W-W+1){rnum_q[W-1]}}, rnum_q[W-2:0]};
      oden_q <= rden_q;
    end
  end

  always_comb begin
    m_axis_tdata_o                   = '0;
    m_axis_tdata_o[NUM_W-1:0]        = onum_q;
    m_axis_tdata_o[OUT_RAW-1:NUM_W]  = oden_q;
  end
  assign m_axis_tvalid_o = ovalid_q;

  far_gcd #(.W(W)) u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(gcd_start),
    .x_i    (gcd_x),
    .y_i    (gcd_y),
    .done_o (gcd_done),
    .gcd_o  (gcd_g)
  );

  far_div #(.W(W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_n),
    .divisor_i (div_d),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_RAW-1:NUM_W] != '0)
    else $error("reduced denominator is zero");

  a_gcd_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_done |-> (state_q == ST_GCD1 || state_q == ST_GCD2))
    else $error("gcd finished outside a gcd state");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVA || state_q == ST_DIVB ||
                  state_q == ST_DIVN || state_q == ST_DIVD))
    else $error("division finished outside a division state");

endmodule

FILE: sv/far_cell.sv
// One bit slice of the divider's partial remainder with its subtract stage.
module far_cell
  import far_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  far_cell_ctrl_t ctrl_i,
  input  logic           shift_in_i,
  input  logic           div_bit_i,
  input  logic           borrow_i,
  input  logic           take_i,
  output logic           rem_o,
  output logic           borrow_o
);

  logic rem_q;
  logic diff;

  assign diff     = shift_in_i ^ div_bit_i ^ borrow_i;
  assign borrow_o = (~shift_in_i & div_bit_i) | (~(shift_in_i ^ div_bit_i) & borrow_i);
  assign rem_o    = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      rem_q <= 1'b0;
    end else if (ctrl_i.step) begin
      rem_q <= take_i ? diff : shift_in_i;
    end
  end

endmodule

FILE: sv/far_div.sv
// Restoring divider built from a row of remainder cells, one quotient bit per cycle.
module far_div
  import far_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   dq_q;
  logic [W-1:0]   dvs_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [W:0]     rem;
  logic [W+1:0]   borrow;
  logic           take;
  far_cell_ctrl_t ctrl;

  assign ctrl.clear = start_i;
  assign ctrl.step  = busy_q;
  assign borrow[0]  = 1'b0;
  // No borrow out of the top slice means the trial subtraction fits.
  assign take       = ~borrow[W+1];

  for (genvar i = 0; i <= W; i++) begin : g_cell
    logic sin;
    logic dbit;
    if (i == 0) begin : g_lo
      assign sin = dq_q[W-1];
    end else begin : g_hi
      assign sin = rem[i-1];
    end
    if (i < W) begin : g_db
      assign dbit = dvs_q[i];
    end else begin : g_top
      assign dbit = 1'b0;
    end
    far_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .shift_in_i(sin),
      .div_bit_i (dbit),
      .borrow_i  (borrow[i]),
      .take_i    (take),
      .rem_o     (rem[i]),
      .borrow_o  (borrow[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q <= {dq_q[W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

FILE: sv/far_gcd.sv
// Binary gcd unit: one shift or subtract step per cycle.
module far_gcd
  import far_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  output logic         done_o,
  output logic [W-1:0] gcd_o
);

  localparam int KW = $clog2(W + 1);

  logic [W-1:0]  x_q, y_q, g_q;
  logic [KW-1:0] k_q;
  logic          busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (x_q == '0 || y_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (x_q == '0) begin
        g_q <= y_q << k_q;
      end else if (y_q == '0) begin
        g_q <= x_q << k_q;
      end else if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q >= y_q) begin
        x_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
  end

  assign done_o = done_q;
  assign gcd_o  = g_q;

endmodule
